/* rtl/csse_pkg.sv */
// Shared types and constants for the cruise set-speed and engagement control unit.
// Holds the item structs, operation and register codes, and the step selection helper.
// Used by every file of the block; depends on nothing.
package csse_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned StepW = 6;
  localparam int unsigned DispW = 9;

  localparam logic [CfgIdxW-1:0] REG_SPEED_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INC_SMALL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INC_LARGE = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEC_SMALL = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEC_LARGE = 3'd5;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_SET_CUR = 3'd1;
  localparam logic [2:0] OP_SET_EXT = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_INC_SM  = 3'd4;
  localparam logic [2:0] OP_INC_LG  = 3'd5;
  localparam logic [2:0] OP_DEC_SM  = 3'd6;
  localparam logic [2:0] OP_DEC_LG  = 3'd7;

  localparam logic [7:0] SPEED_MIN_RST = 8'd30;
  localparam logic [7:0] SPEED_MAX_RST = 8'd180;
  localparam logic [StepW-1:0] STEP_SMALL_RST = 6'd1;
  localparam logic [StepW-1:0] STEP_LARGE_RST = 6'd10;

  typedef enum logic [1:0] {
    ES_STANDARD     = 2'd0,
    ES_AFTER_ENGAGE = 2'd1,
    ES_DURING_OVR   = 2'd2,
    ES_AFTER_OVR    = 2'd3
  } engage_e;

  typedef struct packed {
    logic             cruise_active;
    logic [2:0]       operation;
    logic [DispW-1:0] display_speed;
    logic [7:0]       external_set_speed;
    logic             limiter_function;
    logic             limited;
    logic             override_accel;
    logic             override_decel;
    logic             no_engagement;
    logic             disengagement;
  } in_t;

  typedef struct packed {
    logic       command_enable;
    logic       driver_min_arbitration;
    logic       ready_res;
    logic       override_accel_out;
    logic       override_decel_out;
    logic       speed_stored_out;
    logic [7:0] set_speed_out;
    logic [2:0] operation_out;
    logic [1:0] engage_state_out;
  } out_t;

  // Picks the grid step of an increment or decrement; a zero step acts as one.
  function automatic logic [StepW-1:0] sel_step(input logic [2:0] op,
                                                input logic [StepW-1:0] inc_sm,
                                                input logic [StepW-1:0] inc_lg,
                                                input logic [StepW-1:0] dec_sm,
                                                input logic [StepW-1:0] dec_lg);
    logic [StepW-1:0] s;
    case (op)
      OP_INC_SM: s = inc_sm;
      OP_INC_LG: s = inc_lg;
      OP_DEC_SM: s = dec_sm;
      OP_DEC_LG: s = dec_lg;
      default:   s = StepW'(1);
    endcase
    if (s == '0) begin
      s = StepW'(1);
    end
    return s;
  endfunction

endpackage

/* rtl/csse_div.sv */
// Bit-serial remainder unit: one restoring division step per cycle.
// Gives dividend modulo divisor; uses csse_pkg for the step width.
module csse_div #(
  parameter int unsigned DW = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [csse_pkg::StepW-1:0] divisor_i,
  output logic                      done_o,
  output logic [csse_pkg::StepW-1:0] rem_o
);
  import csse_pkg::*;

  localparam int unsigned CntW = $clog2(DW);
  localparam logic [CntW-1:0] CntLast = CntW'(DW - 1);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dvd_q, dvd_d;
  logic [StepW-1:0] dsr_q, dsr_d;
  logic [StepW-1:0] rem_q, rem_d;
  logic [StepW:0]  trial;

  // The partial remainder stays below the divisor, so one extra bit covers the trial.
  assign trial = {rem_q, dvd_q[DW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = StepW'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = StepW'(trial);
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntLast);
  assign rem_o  = rem_q;

endmodule

/* rtl/cruise_set_speed_engage_control_unit.sv */
// The block takes one item at a time: a new item is accepted only in the idle state, after
// the previous result is committed. The bit-serial remainder unit resolves one bit of the
// stored speed per cycle.
// A result waiting in the output register does not block the next item's division.
// Reset (async, active low) clears the set speed, stored flag, last operation and
// engagement state, and loads the default limits and grid steps.
module cruise_set_speed_engage_control_unit #(
  parameter int unsigned SET_SPEED_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csse_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [csse_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  csse_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output csse_pkg::out_t                 out_data_o
);
  import csse_pkg::*;

  localparam int unsigned SW = SET_SPEED_BITS;
  localparam int unsigned CW = SET_SPEED_BITS + 2;
  localparam logic [CW-1:0] SpeedFull = CW'((1 << SET_SPEED_BITS) - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [7:0]       min_q, max_q;
  logic [StepW-1:0] inc_sm_q, inc_lg_q, dec_sm_q, dec_lg_q;

  logic             stored_q, stored_d;
  logic [SW-1:0]    speed_q, speed_d;
  logic [2:0]       prev_op_q;
  engage_e          es_q, es_d;

  in_t              in_q;
  out_t             out_q, out_d;
  logic             out_valid_q;

  logic             accept, commit;
  logic             div_start, div_done;
  logic [SW-1:0]    div_dividend, speed_base;
  logic [StepW-1:0] div_step, done_step, rem;
  logic [CW-1:0]    speed_wide;

  function automatic logic [SW-1:0] clamp(input logic [CW-1:0] v,
                                          input logic [7:0] lo,
                                          input logic [7:0] hi);
    logic [CW-1:0] r;
    r = v;
    if (r < CW'(lo)) begin
      r = CW'(lo);
    end
    if (r > CW'(hi)) begin
      r = CW'(hi);
    end
    if (r > SpeedFull) begin
      r = SpeedFull;
    end
    return SW'(r);
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= SPEED_MIN_RST;
      max_q    <= SPEED_MAX_RST;
      inc_sm_q <= STEP_SMALL_RST;
      inc_lg_q <= STEP_LARGE_RST;
      dec_sm_q <= STEP_SMALL_RST;
      dec_lg_q <= STEP_LARGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SPEED_MIN: min_q    <= cfg_wdata_i;
        REG_SPEED_MAX: max_q    <= cfg_wdata_i;
        REG_INC_SMALL: inc_sm_q <= cfg_wdata_i[StepW-1:0];
        REG_INC_LARGE: inc_lg_q <= cfg_wdata_i[StepW-1:0];
        REG_DEC_SMALL: dec_sm_q <= cfg_wdata_i[StepW-1:0];
        REG_DEC_LARGE: dec_lg_q <= cfg_wdata_i[StepW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Decrements divide speed - 1, saturating at zero.
  assign speed_base   = (speed_q == '0) ? '0 : speed_q - SW'(1);
  assign div_step     = sel_step(in_data_i.operation, inc_sm_q, inc_lg_q, dec_sm_q, dec_lg_q);
  assign div_dividend = (in_data_i.operation[2] && in_data_i.operation[1]) ? speed_base
                                                                          : speed_q;
  assign div_start    = accept;
  assign done_step    = sel_step(in_q.operation, inc_sm_q, inc_lg_q, dec_sm_q, dec_lg_q);
  assign speed_wide   = CW'(speed_q);

  csse_div #(
    .DW(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_step),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Set-speed update; the grid snap is value minus its remainder.
  always_comb begin
    logic op_chg;
    logic capture;
    op_chg   = (in_q.operation != prev_op_q);
    capture  = 1'b0;
    stored_d = stored_q;
    speed_d  = speed_q;
    if (op_chg) begin
      case (in_q.operation)
        OP_SET_CUR: begin
          stored_d = 1'b1;
          speed_d  = clamp(CW'(in_q.display_speed), min_q, max_q);
        end
        OP_SET_EXT: begin
          stored_d = 1'b1;
          speed_d  = clamp(CW'(in_q.external_set_speed), min_q, max_q);
        end
        OP_CLEAR: begin
          if (!in_q.cruise_active) begin
            stored_d = 1'b0;
            speed_d  = '0;
          end
        end
        OP_INC_SM, OP_INC_LG: begin
          if (stored_q) begin
            speed_d = clamp(speed_wide - CW'(rem) + CW'(done_step), min_q, max_q);
          end else begin
            capture = in_q.cruise_active;
          end
        end
        OP_DEC_SM, OP_DEC_LG: begin
          if (stored_q) begin
            speed_d = clamp(CW'(speed_base) - CW'(rem), min_q, max_q);
          end else begin
            capture = in_q.cruise_active;
          end
        end
        default: begin
          capture = in_q.cruise_active && !stored_q;
        end
      endcase
    end
    if (capture) begin
      stored_d = 1'b1;
      speed_d  = clamp(CW'(in_q.display_speed), min_q, max_q);
    end
  end

  // Engagement state, advanced only on active items.
  always_comb begin
    engage_e es_start;
    es_start = es_q;
    es_d     = es_q;
    if (in_q.cruise_active) begin
      if ((in_q.operation != prev_op_q) && (in_q.operation != OP_NONE)) begin
        es_start = ES_STANDARD;
      end
      es_d = es_start;
      case (es_start)
        ES_STANDARD: begin
          if (in_q.override_accel) es_d = ES_DURING_OVR;
        end
        ES_AFTER_ENGAGE: begin
          if (in_q.override_accel) es_d = ES_DURING_OVR;
          else if (!in_q.limited) es_d = ES_STANDARD;
        end
        ES_DURING_OVR: begin
          if (!in_q.override_accel) es_d = ES_AFTER_OVR;
        end
        default: begin
          if (!in_q.limited) es_d = ES_STANDARD;
        end
      endcase
    end
  end

  always_comb begin
    logic [CW-1:0] sp;
    sp = CW'(speed_d);
    out_d.command_enable         = in_q.cruise_active;
    out_d.driver_min_arbitration = in_q.cruise_active && in_q.limiter_function;
    out_d.ready_res              = in_q.cruise_active ? !in_q.disengagement
                                                      : !in_q.no_engagement;
    out_d.override_accel_out     = in_q.cruise_active && in_q.override_accel;
    out_d.override_decel_out     = in_q.cruise_active && in_q.override_decel;
    out_d.speed_stored_out       = stored_d;
    out_d.set_speed_out          = sp[7:0];
    out_d.operation_out          = in_q.operation;
    out_d.engage_state_out       = es_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stored_q    <= 1'b0;
      speed_q     <= '0;
      prev_op_q   <= OP_NONE;
      es_q        <= ES_STANDARD;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        stored_q    <= stored_d;
        speed_q     <= speed_d;
        prev_op_q   <= in_q.operation;
        es_q        <= es_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/csse_chk.sv */
// Port-level checker for the cruise set-speed and engagement control unit.
// Depends on csse_pkg for the result struct; bound to the top level at the end of the file.
module csse_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input csse_pkg::out_t out_data_o
);
  import csse_pkg::*;

  // The block works on one item at a time, so it closes right after taking one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still open after an item was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("waiting result changed or dropped");

  a_passive_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.command_enable) |->
      (!out_data_o.override_accel_out && !out_data_o.override_decel_out &&
       !out_data_o.driver_min_arbitration))
    else $error("passive item reports override or arbitration");

  // Nothing stored means the set speed was cleared or never set.
  a_empty_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.speed_stored_out) |-> (out_data_o.set_speed_out == 8'd0))
    else $error("set speed nonzero with nothing stored");

  a_no_after_engage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.engage_state_out != ES_AFTER_ENGAGE))
    else $error("after-engagement state reported");

endmodule

bind cruise_set_speed_engage_control_unit csse_chk u_csse_chk (.*);

/* dv/cruise_set_speed_engage_control_unit_tb.sv */
// Self-checking testbench for the cruise set-speed and engagement control unit.
// Drives items over valid/ready with random gaps and stalls and checks every status word against
// an in-bench predictor or a typed row's own status. Depends on csse_pkg and the unit's RTL only.
module cruise_set_speed_engage_control_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csse_pkg::*;

  localparam int unsigned SpeedBits      = 8;
  localparam int unsigned SpeedFull      = (1 << SpeedBits) - 1;
  localparam int unsigned DrainCycles    = SpeedBits + 6;
  localparam int unsigned PhaseCount     = 6;
  localparam int unsigned PhaseItems     = 238;
  localparam int unsigned RandomItems    = PhaseCount * PhaseItems;
  localparam int unsigned PressureAt     = 1100;
  localparam int unsigned PressureCycles = 300;
  localparam int unsigned MaxPrinted     = 40;
  localparam int unsigned LimitNs        = 5_000_000;
  localparam int          DirCount       = 24;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  localparam out_t Untyped = '0;

  // Flag columns of an item: {limiter, limited, ovr_accel, ovr_decel, no_engage, disengage}.
  // Typed status columns: {cmd_en, min_arb, ready, ovr_acc, ovr_dec, stored}, speed, op, state.
  typedef struct packed {
    logic typed;
    in_t  item;
    out_t status;
  } dir_row_t;

  localparam dir_row_t DirTable [DirCount] = '{
    {1'b1, {1'b0, OP_NONE,    9'd0,   8'd0,   6'b000000},
           {6'b001000, 8'd0,   OP_NONE,    ES_STANDARD}},
    {1'b1, {1'b0, OP_NONE,    9'd511, 8'd255, 6'b111111},
           {6'b000000, 8'd0,   OP_NONE,    ES_STANDARD}},
    {1'b1, {1'b1, OP_NONE,    9'd511, 8'd0,   6'b100000},
           {6'b111000, 8'd0,   OP_NONE,    ES_STANDARD}},
    {1'b1, {1'b1, OP_SET_EXT, 9'd0,   8'd0,   6'b001101},
           {6'b100111, 8'd30,  OP_SET_EXT, ES_DURING_OVR}},
    {1'b0, {1'b1, OP_SET_EXT, 9'd100, 8'd255, 6'b010000}, Untyped},
    {1'b0, {1'b1, OP_SET_EXT, 9'd100, 8'd255, 6'b010000}, Untyped},
    {1'b0, {1'b1, OP_SET_EXT, 9'd0,   8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_SET_CUR, 9'd0,   8'd0,   6'b001000}, Untyped},
    {1'b0, {1'b1, OP_INC_SM,  9'd300, 8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_INC_LG,  9'd300, 8'd0,   6'b100000}, Untyped},
    {1'b0, {1'b1, OP_DEC_SM,  9'd0,   8'd0,   6'b000010}, Untyped},
    {1'b0, {1'b1, OP_DEC_LG,  9'd0,   8'd0,   6'b000001}, Untyped},
    {1'b1, {1'b0, OP_CLEAR,   9'd90,  8'd0,   6'b000000},
           {6'b001000, 8'd0,   OP_CLEAR,   ES_STANDARD}},
    {1'b0, {1'b1, OP_DEC_SM,  9'd120, 8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_CLEAR,   9'd0,   8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b0, OP_INC_LG,  9'd90,  8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b0, OP_CLEAR,   9'd90,  8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b0, OP_DEC_LG,  9'd90,  8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_DEC_LG,  9'd90,  8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_NONE,    9'd25,  8'd0,   6'b000000}, Untyped},
    {1'b0, {1'b1, OP_SET_EXT, 9'd0,   8'd255, 6'b001000}, Untyped},
    {1'b0, {1'b1, OP_NONE,    9'd0,   8'd0,   6'b011000}, Untyped},
    {1'b0, {1'b1, OP_NONE,    9'd0,   8'd0,   6'b010000}, Untyped},
    {1'b0, {1'b1, OP_INC_SM,  9'd0,   8'd0,   6'b010000}, Untyped}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  // Predictor copy of the registers and of the block state.
  int unsigned lim_lo;
  int unsigned lim_hi;
  logic [StepW-1:0] step_inc_sm;
  logic [StepW-1:0] step_inc_lg;
  logic [StepW-1:0] step_dec_sm;
  logic [StepW-1:0] step_dec_lg;
  logic speed_held;
  int unsigned cur_speed;
  logic [2:0] last_op;
  engage_e eng_state;

  out_t pending_status [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  int unsigned rand_sent = 0;
  int unsigned items_sent = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings = 0;
  int unsigned eng_seen [4] = '{0, 0, 0, 0};
  int unsigned speed_seen_lo = SpeedFull;
  int unsigned speed_seen_hi = 0;

  // Shaping state of the random items: the accelerator override and limiting persist for a while.
  logic acc_hold = 1'b0;
  logic lim_hold = 1'b0;
  logic [2:0] last_rand_op = OP_NONE;

  cruise_set_speed_engage_control_unit #(
    .SET_SPEED_BITS(SpeedBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_set_speed(int unsigned v);
    if (v < lim_lo) v = lim_lo;
    if (v > lim_hi) v = lim_hi;
    if (v > SpeedFull) v = SpeedFull;
    return v;
  endfunction

  function automatic int unsigned grid_step(logic [2:0] op);
    logic [StepW-1:0] s;
    case (op)
      OP_INC_SM: s = step_inc_sm;
      OP_INC_LG: s = step_inc_lg;
      OP_DEC_SM: s = step_dec_sm;
      default:   s = step_dec_lg;
    endcase
    return (s == '0) ? 1 : int'(s);
  endfunction

  // Applies one item to the predictor state and returns the status word it should give.
  function automatic out_t predict_status(in_t it);
    out_t o;
    int unsigned step;
    int unsigned base;
    logic [2:0] op;
    logic active;
    op = it.operation;
    active = it.cruise_active;
    if (op != last_op) begin
      case (op)
        OP_SET_CUR: begin
          speed_held = 1'b1;
          cur_speed = clamp_set_speed(it.display_speed);
        end
        OP_SET_EXT: begin
          speed_held = 1'b1;
          cur_speed = clamp_set_speed(it.external_set_speed);
        end
        OP_CLEAR: begin
          if (!active) begin
            speed_held = 1'b0;
            cur_speed = 0;
          end
        end
        OP_INC_SM, OP_INC_LG, OP_DEC_SM, OP_DEC_LG: begin
          if (speed_held) begin
            step = grid_step(op);
            if (op == OP_INC_SM || op == OP_INC_LG) begin
              cur_speed = clamp_set_speed((cur_speed / step) * step + step);
            end else begin
              base = (cur_speed == 0) ? 0 : cur_speed - 1;
              cur_speed = clamp_set_speed((base / step) * step);
            end
          end else if (active) begin
            speed_held = 1'b1;
            cur_speed = clamp_set_speed(it.display_speed);
          end
        end
        default: begin
          if (active && !speed_held) begin
            speed_held = 1'b1;
            cur_speed = clamp_set_speed(it.display_speed);
          end
        end
      endcase
    end
    if (active) begin
      if (op != last_op && op != OP_NONE) eng_state = ES_STANDARD;
      case (eng_state)
        ES_STANDARD: begin
          if (it.override_accel) eng_state = ES_DURING_OVR;
        end
        ES_AFTER_ENGAGE: begin
          if (it.override_accel) eng_state = ES_DURING_OVR;
          else if (!it.limited) eng_state = ES_STANDARD;
        end
        ES_DURING_OVR: begin
          if (!it.override_accel) eng_state = ES_AFTER_OVR;
        end
        default: begin
          if (!it.limited) eng_state = ES_STANDARD;
        end
      endcase
    end
    last_op = op;
    o.command_enable = active;
    o.driver_min_arbitration = active && it.limiter_function;
    o.ready_res = active ? !it.disengagement : !it.no_engagement;
    o.override_accel_out = active && it.override_accel;
    o.override_decel_out = active && it.override_decel;
    o.speed_stored_out = speed_held;
    o.set_speed_out = 8'(cur_speed);
    o.operation_out = op;
    o.engage_state_out = eng_state;
    return o;
  endfunction

  // Mostly plausible driving sequences: ops repeat often, accelerator override and limiting come and go in runs.
  function automatic in_t next_random_item();
    in_t it;
    logic [31:0] r;
    if ($urandom_range(0, 99) < 10) begin
      r = $urandom;
      it = r[$bits(in_t)-1:0];
    end else begin
      it.cruise_active = ($urandom_range(0, 99) < 75);
      it.operation = ($urandom_range(0, 99) < 40) ? last_rand_op : 3'($urandom);
      if ($urandom_range(0, 99) < 5) it.display_speed = '0;
      else if ($urandom_range(0, 99) < 80) it.display_speed = 9'($urandom_range(0, 260));
      else it.display_speed = 9'($urandom);
      it.external_set_speed = ($urandom_range(0, 99) < 5) ? 8'd0 : 8'($urandom);
      if ($urandom_range(0, 4) == 0) acc_hold = !acc_hold;
      if ($urandom_range(0, 3) == 0) lim_hold = !lim_hold;
      it.limiter_function = 1'($urandom);
      it.limited = lim_hold;
      it.override_accel = acc_hold;
      it.override_decel = ($urandom_range(0, 99) < 30);
      it.no_engagement = ($urandom_range(0, 99) < 10);
      it.disengagement = ($urandom_range(0, 99) < 10);
    end
    last_rand_op = it.operation;
    return it;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MaxPrinted) begin
      $display("MISMATCH at status word %0d (%0t): %s", checked, $realtime, what);
    end
    mismatches++;
  endtask

  task automatic check_status(out_t got);
    out_t want;
    if (pending_status.size() == 0) begin
      report_mismatch($sformatf("status word %h arrived with none outstanding", got));
      return;
    end
    want = pending_status.pop_front();
    if (got.command_enable !== want.command_enable)
      report_mismatch($sformatf("command_enable %b, expected %b",
                                got.command_enable, want.command_enable));
    if (got.driver_min_arbitration !== want.driver_min_arbitration)
      report_mismatch($sformatf("driver_min_arbitration %b, expected %b",
                                got.driver_min_arbitration, want.driver_min_arbitration));
    if (got.ready_res !== want.ready_res)
      report_mismatch($sformatf("ready_res %b, expected %b", got.ready_res, want.ready_res));
    if (got.override_accel_out !== want.override_accel_out)
      report_mismatch($sformatf("override_accel_out %b, expected %b",
                                got.override_accel_out, want.override_accel_out));
    if (got.override_decel_out !== want.override_decel_out)
      report_mismatch($sformatf("override_decel_out %b, expected %b",
                                got.override_decel_out, want.override_decel_out));
    if (got.speed_stored_out !== want.speed_stored_out)
      report_mismatch($sformatf("speed_stored_out %b, expected %b",
                                got.speed_stored_out, want.speed_stored_out));
    if (got.set_speed_out !== want.set_speed_out)
      report_mismatch($sformatf("set_speed_out %0d, expected %0d",
                                got.set_speed_out, want.set_speed_out));
    if (got.operation_out !== want.operation_out)
      report_mismatch($sformatf("operation_out %0d, expected %0d",
                                got.operation_out, want.operation_out));
    if (got.engage_state_out !== want.engage_state_out)
      report_mismatch($sformatf("engage_state_out %0d, expected %0d",
                                got.engage_state_out, want.engage_state_out));
    eng_seen[want.engage_state_out]++;
    if (want.speed_stored_out) begin
      if (want.set_speed_out < speed_seen_lo) speed_seen_lo = want.set_speed_out;
      if (want.set_speed_out > speed_seen_hi) speed_seen_hi = want.set_speed_out;
    end
    checked++;
  endtask

  // Offers one item, holding valid and payload until accepted, then records its status.
  task automatic send_item(in_t it, logic typed, out_t status);
    out_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_status(it);
    pending_status.push_back(typed ? status : predicted);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_SPEED_MIN: lim_lo = data;
      REG_SPEED_MAX: lim_hi = data;
      REG_INC_SMALL: step_inc_sm = data[StepW-1:0];
      REG_INC_LARGE: step_inc_lg = data[StepW-1:0];
      REG_DEC_SMALL: step_dec_sm = data[StepW-1:0];
      REG_DEC_LARGE: step_dec_lg = data[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Phase settings: defaults, full range with zero steps, min above max with steps of 50,
  // steps with upper data bits set, then random limits and steps.
  task automatic apply_settings(int unsigned phase);
    logic [CfgDataW-1:0] vals [6];
    logic [CfgIdxW-1:0] order [6];
    order = '{REG_SPEED_MIN, REG_SPEED_MAX, REG_INC_SMALL,
              REG_INC_LARGE, REG_DEC_SMALL, REG_DEC_LARGE};
    case (phase)
      0: vals = '{SPEED_MIN_RST, SPEED_MAX_RST, 8'(STEP_SMALL_RST),
                  8'(STEP_LARGE_RST), 8'(STEP_SMALL_RST), 8'(STEP_LARGE_RST)};
      1: vals = '{8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
      2: vals = '{8'd200, 8'd50, 8'd50, 8'd50, 8'd50, 8'd50};
      3: vals = '{8'd1, 8'd255, 8'hFF, 8'hC7, 8'd3, 8'd50};
      default: begin
        vals[0] = 8'($urandom_range(1, 120));
        vals[1] = 8'($urandom_range(100, 255));
        for (int j = 2; j < 6; j++) vals[j] = 8'($urandom_range(1, 50));
      end
    endcase
    for (int j = 0; j < 6; j++) write_reg(order[j], vals[j]);
    write_reg(REG_SPARE_LO, 8'($urandom));
    write_reg(REG_SPARE_HI, 8'($urandom));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    #(LimitNs);
    $display("Timeout: %0d status words still outstanding", pending_status.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_status(out_data_o);
      out_ready_i <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long output stall while the sender keeps offering, so the unit backs up into its input.
  initial begin
    while (rand_sent < PressureAt) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (PressureCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    lim_lo = SPEED_MIN_RST;
    lim_hi = SPEED_MAX_RST;
    step_inc_sm = STEP_SMALL_RST;
    step_inc_lg = STEP_LARGE_RST;
    step_dec_sm = STEP_SMALL_RST;
    step_dec_lg = STEP_LARGE_RST;
    speed_held = 1'b0;
    cur_speed = 0;
    last_op = OP_NONE;
    eng_state = ES_STANDARD;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 9;
    rx_idle_pct = 74;
    for (int i = 0; i < DirCount; i++) begin
      send_item(DirTable[i].item, DirTable[i].typed, DirTable[i].status);
    end

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      in_valid_i <= 1'b0;
      wait_idle();
      apply_settings(p);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if (rand_sent < RandomItems / 3) begin
          tx_idle_pct = 9;
          rx_idle_pct = 74;
        end else if (rand_sent < 2 * RandomItems / 3) begin
          tx_idle_pct = 74;
          rx_idle_pct = 9;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        send_item(next_random_item(), 1'b0, Untyped);
        rand_sent++;
      end
    end
    in_valid_i <= 1'b0;

    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles + 6) @(posedge clk_i);

    $display("Run covered %0d items (%0d from the directed table) under %0d register settings;",
             items_sent, DirCount, settings + 1);
    $display("%0d status words checked, states standard/override/after %0d/%0d/%0d, speeds %0d..%0d.",
             checked, eng_seen[ES_STANDARD], eng_seen[ES_DURING_OVR], eng_seen[ES_AFTER_OVR],
             speed_seen_lo, speed_seen_hi);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
